// ===== hw/rtl/set_assoc_lru_cache_sim_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LRU cache model
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

`ifndef SYNTHESIS

// condition that holds at every clock edge
`define SLC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("slc check failed");

// antecedent in this cycle implies consequent in the next one
`define SLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slc check failed");

`else

`define SLC_ASSERT(lbl, cond)
`define SLC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types, codes and helpers of the LRU cache model.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    localparam int ADDR_W    = 64;
    localparam int TAG_W     = 64;
    localparam int CNT_W     = 48;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    // access kinds
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // access outcomes
    localparam logic [1:0] OUTCOME_HIT   = 2'd0;
    localparam logic [1:0] OUTCOME_FILL  = 2'd1;
    localparam logic [1:0] OUTCOME_EVICT = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] address;
    } slc_req_t;

    typedef struct packed {
        logic [1:0]       outcome;
        logic             last_of_run;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } slc_rsp_t;

    // lookup status handed from the way selector to the controller
    typedef struct packed {
        logic       hit;
        logic       evict;
        logic [1:0] outcome;
    } slc_look_t;

    // saturating counter step
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

// ===== hw/rtl/slc_row_mem.sv =====
// ----------------------------------------------------------------------------
// slc_row_mem
// One-port-write, one-port-read set memory with registered read data.
// ----------------------------------------------------------------------------
module slc_row_mem #(
    parameter int ROWS   = 64,
    parameter int ROW_W  = 8,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ROW_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/slc_way_sel.sv =====
// ----------------------------------------------------------------------------
// slc_way_sel
// Tag match, fill/victim choice and LRU rank update for one set.
// ----------------------------------------------------------------------------
module slc_way_sel #(
    parameter int MAX_WAYS = 8,
    parameter int RW       = 3,
    parameter int NWW      = 4,
    parameter int ROW_W    = 8
) (
    input  logic [ROW_W-1:0]         row,
    input  logic                     row_ok,
    input  logic [slc_pkg::TAG_W-1:0] tag,
    input  logic [NWW-1:0]           nw,
    input  logic                     twice,
    output logic [ROW_W-1:0]         row_upd,
    output slc_pkg::slc_look_t       look
);
    import slc_pkg::*;

    localparam int EW  = TAG_W + 1 + RW;
    localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [RW-1:0]    rk    [MAX_WAYS];
    logic             vl    [MAX_WAYS];
    logic             inuse [MAX_WAYS];
    logic             hit;
    logic             free_found;
    logic [WIW-1:0]   hit_w;
    logic [WIW-1:0]   free_w;
    logic [WIW-1:0]   victim_w;
    logic [WIW-1:0]   sel;
    logic [RW-1:0]    old_rank;
    logic [RW-1:0]    top_rank;

    // unpack ways; a row never written reads as all invalid, rank zero
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            inuse[w] = (NWW'(w) < nw);
            vl[w]    = row_ok & row[w*EW + RW];
            rk[w]    = row_ok ? row[w*EW +: RW] : '0;
        end
    end

    // first matching way, first empty way, lowest-rank way
    always_comb
    begin
        hit        = 1'b0;
        hit_w      = '0;
        free_found = 1'b0;
        free_w     = '0;
        victim_w   = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (inuse[w] && vl[w] && !hit && (row[w*EW + RW + 1 +: TAG_W] == tag))
            begin
                hit   = 1'b1;
                hit_w = WIW'(w);
            end
            if (inuse[w] && !vl[w] && !free_found)
            begin
                free_found = 1'b1;
                free_w     = WIW'(w);
            end
        end
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (inuse[w] && (rk[w] < rk[victim_w]))
            begin
                victim_w = WIW'(w);
            end
        end
    end

    always_comb
    begin
        priority if (hit)
        begin
            sel          = hit_w;
            look.outcome = OUTCOME_HIT;
        end
        else if (free_found)
        begin
            sel          = free_w;
            look.outcome = OUTCOME_FILL;
        end
        else
        begin
            sel          = victim_w;
            look.outcome = OUTCOME_EVICT;
        end
        look.hit   = hit;
        look.evict = !hit && !free_found;
    end

    assign old_rank = rk[sel];
    assign top_rank = RW'(nw - 1'b1);

    // rebuild the row: touched way becomes newest, newer ways step down;
    // with twice set the second touch of a modify is folded in, which only
    // moves ways still ranked above the newest slot (after a ways decrease)
    always_comb
    begin
        logic [RW-1:0] rank_new;
        row_upd  = row;
        rank_new = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            row_upd[w*EW + RW] = vl[w];
            row_upd[w*EW +: RW] = rk[w];
            if (inuse[w])
            begin
                if (WIW'(w) == sel)
                begin
                    row_upd[w*EW +: RW]            = top_rank;
                    row_upd[w*EW + RW]             = 1'b1;
                    row_upd[w*EW + RW + 1 +: TAG_W] = tag;
                end
                else
                begin
                    rank_new = rk[w];
                    if (rk[w] > old_rank)
                    begin
                        rank_new = rk[w] - 1'b1;
                    end
                    if (twice && (rank_new > top_rank))
                    begin
                        rank_new = rank_new - 1'b1;
                    end
                    row_upd[w*EW +: RW] = rank_new;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/set_assoc_lru_cache_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache model with true LRU replacement and hit/miss totals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_req) carries one access request:
//   load, store or modify plus a 64-bit byte address. Output channel
//   (out_valid/out_stall/out_rsp) returns one result per load or store with the
//   outcome and the running saturating totals; a modify gives two results,
//   the first with last_of_run low. A request with op 3 is taken and dropped.
//   A load or store is a set memory read on accept, then lookup and
//   writeback in S_LOOK; a modify adds S_SECOND, its second result (always
//   a hit) following the first. No new request is taken until the sequencer
//   is back in S_IDLE, since in_stall is high in every other state.
//   The result sits in an output register; while it is held with out_stall
//   high the lookup waits and in_stall stays high.
//   Reset clears the geometry registers (1 set, 1 way, no offset bits), the
//   totals and the per-set valid flags; no memory clearing pass is needed.
//   Geometry registers are written via cfg_we/cfg_index/cfg_data; the user must
//   write only while idle, not enforced here; stored lines survive a change.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = slc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = slc_pkg::DEF_MAX_WAYS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  slc_pkg::slc_req_t              in_req,
    output logic                           out_valid,
    input  logic                           out_stall,
    output slc_pkg::slc_rsp_t              out_rsp
);
    import slc_pkg::*;

`include "set_assoc_lru_cache_sim_macros.svh"

    localparam int ROWS  = 1 << MAX_SET_BITS;
    localparam int SIW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NWW   = $clog2(MAX_WAYS + 1);
    localparam int EW    = TAG_W + 1 + RW;
    localparam int ROW_W = MAX_WAYS * EW;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOK   = 3'b010,
        S_SECOND = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]       set_bits_reg;
    logic [3:0]       ways_reg;
    logic [4:0]       block_bits_reg;

    logic [1:0]       op_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [SIW-1:0]   set_reg;
    logic [NWW-1:0]   nw_reg;
    logic             row_ok_reg;
    logic [ROWS-1:0]  row_valid_reg;

    logic [CNT_W-1:0] hits_reg, hits_next;
    logic [CNT_W-1:0] misses_reg, misses_next;
    logic [CNT_W-1:0] evictions_reg, evictions_next;

    logic             out_valid_reg, out_valid_next;
    slc_rsp_t         rsp_reg;

    logic             accept;
    logic             slot_free;
    logic             commit;
    logic             second;
    logic [3:0]       sb_eff;
    logic [5:0]       tag_shift;
    logic [ADDR_W-1:0] set_full;
    logic [SIW-1:0]   set_in;
    logic [TAG_W-1:0] tag_in;
    logic [4:0]       nw_full;
    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_upd;
    slc_look_t        look;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            ways_reg       <= 4'd1;
            block_bits_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_WAYS:       ways_reg       <= cfg_data[3:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // address split under the current geometry
    always_comb
    begin
        sb_eff    = (4'(set_bits_reg) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                          : 4'(set_bits_reg);
        tag_shift = 6'(block_bits_reg) + 6'(sb_eff);
        set_full  = (in_req.address >> block_bits_reg)
                    & ((64'd1 << sb_eff) - 64'd1);
        set_in    = set_full[SIW-1:0];
        tag_in    = in_req.address >> tag_shift;
        if (ways_reg == 4'd0)
        begin
            nw_full = 5'd1;
        end
        else if (5'(ways_reg) > 5'(MAX_WAYS))
        begin
            nw_full = 5'(MAX_WAYS);
        end
        else
        begin
            nw_full = 5'(ways_reg);
        end
    end

    // handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == S_LOOK) && slot_free;
    assign second    = (state_reg == S_SECOND) && slot_free;

    // set memory
    slc_row_mem #(
        .ROWS   (ROWS),
        .ROW_W  (ROW_W),
        .ADDR_W (SIW)
    ) u_mem (
        .clk   (clk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (row_upd),
        .re    (accept),
        .raddr (set_in),
        .rdata (row_rd)
    );

    // a modify writes back the row as it stands after both of its accesses
    slc_way_sel #(
        .MAX_WAYS (MAX_WAYS),
        .RW       (RW),
        .NWW      (NWW),
        .ROW_W    (ROW_W)
    ) u_sel (
        .row     (row_rd),
        .row_ok  (row_ok_reg),
        .tag     (tag_reg),
        .nw      (nw_reg),
        .twice   (op_reg == OP_MODIFY),
        .row_upd (row_upd),
        .look    (look)
    );

    // latched request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= in_req.op;
            tag_reg <= tag_in;
            set_reg <= set_in;
            nw_reg  <= NWW'(nw_full);
        end
    end

    // per-set written flags, stand in for the cleared valid and rank bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_ok_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_ok_reg <= row_valid_reg[set_in];
            end
            if (commit)
            begin
                row_valid_reg[set_reg] <= 1'b1;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_req.op != OP_NONE))
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (slot_free)
                begin
                    state_next = (op_reg == OP_MODIFY) ? S_SECOND : S_IDLE;
                end
            end
            S_SECOND:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // running totals
    always_comb
    begin
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        evictions_next = evictions_reg;
        if ((commit && look.hit) || second)
        begin
            hits_next = sat_inc(hits_reg);
        end
        if (commit && !look.hit)
        begin
            misses_next = sat_inc(misses_reg);
        end
        if (commit && look.evict)
        begin
            evictions_next = sat_inc(evictions_reg);
        end
    end

    assign out_valid_next = (commit || second) ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            evictions_reg <= evictions_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (commit || second)
        begin
            rsp_reg.outcome        <= second ? OUTCOME_HIT : look.outcome;
            rsp_reg.last_of_run    <= second || (op_reg != OP_MODIFY);
            rsp_reg.hit_total      <= hits_next;
            rsp_reg.miss_total     <= misses_next;
            rsp_reg.eviction_total <= evictions_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = rsp_reg;

    // checks
    `SLC_ASSERT_NEXT(a_accept_to_look, accept && (in_req.op != OP_NONE), state_reg == S_LOOK)
    `SLC_ASSERT(a_second_is_modify, (state_reg != S_SECOND) || (op_reg == OP_MODIFY))
    `SLC_ASSERT(a_evict_le_miss, evictions_reg <= misses_reg)
    `SLC_ASSERT_NEXT(a_hits_monotonic, 1'b1, hits_reg >= $past(hits_reg))

endmodule
